/* rtl/bplb_pkg.sv */
package bplb_pkg;

	localparam int TICK_W    = 10;
	localparam int MS_W      = 16;
	localparam int HOLD_W    = 17;
	localparam int PHASE_W   = 11;
	localparam int PAT_W     = 10;
	localparam int MODE_W    = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [TICK_W-1:0] TICK_MS_RST   = 10'd20;
	localparam logic [MS_W-1:0]   DEBOUNCE_RST  = 16'd40;
	localparam logic [MS_W-1:0]   LONG_RST      = 16'd2000;
	localparam logic [MS_W-1:0]   VERY_LONG_RST = 16'd10000;

	localparam logic [CFG_IDX_W-1:0] REG_TICK_MS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG = 2'd3;

	localparam logic [MODE_W-1:0] MODE_UNPAIRED  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SEARCHING = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CONNECTED = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RECORDING = 3'd3;
	localparam logic [MODE_W-1:0] MODE_WARNING   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CONFIG    = 3'd5;

	typedef struct packed {
		logic short_press;
		logic long_press;
		logic very_long_press;
	} press_evt_t;

	// on time of each pattern in ms; a zero on time with nonzero off time is dark
	function automatic logic [PAT_W-1:0] pat_on(input logic [MODE_W-1:0] mode);
		logic [PAT_W-1:0] r;
		case (mode)
			MODE_UNPAIRED:  r = 10'd0;
			MODE_SEARCHING: r = 10'd120;
			MODE_CONNECTED: r = 10'd1;
			MODE_RECORDING: r = 10'd900;
			MODE_WARNING:   r = 10'd120;
			MODE_CONFIG:    r = 10'd0;
			default:        r = 10'd0;
		endcase
		return r;
	endfunction

	// off time of each pattern in ms; zero means solid on
	function automatic logic [PAT_W-1:0] pat_off(input logic [MODE_W-1:0] mode);
		logic [PAT_W-1:0] r;
		case (mode)
			MODE_UNPAIRED:  r = 10'd1;
			MODE_SEARCHING: r = 10'd880;
			MODE_CONNECTED: r = 10'd0;
			MODE_RECORDING: r = 10'd100;
			MODE_WARNING:   r = 10'd120;
			MODE_CONFIG:    r = 10'd1;
			default:        r = 10'd1;
		endcase
		return r;
	endfunction

endpackage

/* rtl/button_press_classifier_led_blinker.sv */
// Button press classifier and LED blinker. Each accepted input request is one
// timer tick of tick_ms milliseconds and yields exactly one result request with
// the short, long and very-long press flags and the LED drive for that tick.
// One request is taken every clock cycle while results are accepted; a result is
// presented after its input passes the input register, then the result register.
// While a result waits, one more request can enter the input register, after
// which input stalls until the result is taken.
// Configuration writes (index 0 tick_ms, 1 settle time, 2 long_press_ms,
// 3 very_long_press_ms) are always ready and must only be issued while idle.
module button_press_classifier_led_blinker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              button_down,
	input  logic [bplb_pkg::MODE_W-1:0]       led_mode,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              short_press,
	output logic                              long_press,
	output logic                              very_long_press,
	output logic                              led_on,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bplb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bplb_pkg::MS_W-1:0]         cfg_data
);

	logic [bplb_pkg::TICK_W-1:0] tick_ms_q;
	logic [bplb_pkg::MS_W-1:0]   debounce_q, long_q, vlong_q;

	logic                        valid_s1;
	logic                        button_s1;
	logic [bplb_pkg::MODE_W-1:0] mode_s1;
	logic                        step;
	bplb_pkg::press_evt_t        evt;
	logic                        led;

	logic                        out_valid_q;
	logic                        short_q, long_evt_q, vlong_evt_q, led_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_ms_q  <= bplb_pkg::TICK_MS_RST;
			debounce_q <= bplb_pkg::DEBOUNCE_RST;
			long_q     <= bplb_pkg::LONG_RST;
			vlong_q    <= bplb_pkg::VERY_LONG_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				bplb_pkg::REG_TICK_MS:   tick_ms_q  <= cfg_data[bplb_pkg::TICK_W-1:0];
				bplb_pkg::REG_DEBOUNCE:  debounce_q <= cfg_data;
				bplb_pkg::REG_LONG:      long_q     <= cfg_data;
				bplb_pkg::REG_VERY_LONG: vlong_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			button_s1 <= button_down;
			mode_s1   <= led_mode;
		end
	end

	bplb_press u_press (
		.clk                (clk),
		.arst_n             (arst_n),
		.step               (step),
		.button_down        (button_s1),
		.tick_ms            (tick_ms_q),
		.settle_ms          (debounce_q),
		.long_press_ms      (long_q),
		.very_long_press_ms (vlong_q),
		.evt                (evt)
	);

	bplb_led u_led (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.led_mode (mode_s1),
		.tick_ms  (tick_ms_q),
		.led_on   (led)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			short_q     <= evt.short_press;
			long_evt_q  <= evt.long_press;
			vlong_evt_q <= evt.very_long_press;
			led_q       <= led;
		end
	end

	assign out_valid       = out_valid_q;
	assign short_press     = short_q;
	assign long_press      = long_evt_q;
	assign very_long_press = vlong_evt_q;
	assign led_on          = led_q;

endmodule

/* rtl/bplb_press.sv */
module bplb_press (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic                            button_down,
	input  logic [bplb_pkg::TICK_W-1:0]     tick_ms,
	input  logic [bplb_pkg::MS_W-1:0]       settle_ms,
	input  logic [bplb_pkg::MS_W-1:0]       long_press_ms,
	input  logic [bplb_pkg::MS_W-1:0]       very_long_press_ms,
	output bplb_pkg::press_evt_t            evt
);

	logic                          last_q, last_d;
	logic [bplb_pkg::MS_W-1:0]     stable_q, stable_d;
	logic                          pressed_q, pressed_d;
	logic [bplb_pkg::HOLD_W-1:0]   hold_q, hold_d;
	logic                          long_done_q, long_done_d;
	logic                          vlong_done_q, vlong_done_d;
	logic [bplb_pkg::MS_W:0]       stable_sum;
	logic [bplb_pkg::MS_W-1:0]     stable_sat;
	logic [bplb_pkg::HOLD_W:0]     hold_sum;

	always_comb begin
		last_d       = last_q;
		stable_d     = stable_q;
		pressed_d    = pressed_q;
		hold_d       = hold_q;
		long_done_d  = long_done_q;
		vlong_done_d = vlong_done_q;
		evt          = '0;
		stable_sum   = {1'b0, stable_q} + (bplb_pkg::MS_W + 1)'(tick_ms);
		stable_sat   = stable_sum[bplb_pkg::MS_W] ? '1 : stable_sum[bplb_pkg::MS_W-1:0];
		hold_sum     = '0;

		if (button_down != last_q) begin
			last_d   = button_down;
			stable_d = '0;
		end else if (stable_q < settle_ms) begin
			stable_d = stable_sat;
			if (stable_sat >= settle_ms) begin
				if (button_down && !pressed_q) begin
					pressed_d    = 1'b1;
					hold_d       = '0;
					long_done_d  = 1'b0;
					vlong_done_d = 1'b0;
				end else if (!button_down && pressed_q) begin
					pressed_d       = 1'b0;
					evt.short_press = !long_done_q;
				end
			end
		end

		if (pressed_d) begin
			hold_sum = {1'b0, hold_d} + (bplb_pkg::HOLD_W + 1)'(tick_ms);
			hold_d   = hold_sum[bplb_pkg::HOLD_W] ? '1 : hold_sum[bplb_pkg::HOLD_W-1:0];
			if (!long_done_d && hold_d >= bplb_pkg::HOLD_W'(long_press_ms)) begin
				long_done_d    = 1'b1;
				evt.long_press = 1'b1;
			end
			if (!vlong_done_d && hold_d >= bplb_pkg::HOLD_W'(very_long_press_ms)) begin
				vlong_done_d        = 1'b1;
				evt.very_long_press = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q       <= 1'b0;
			stable_q     <= '0;
			pressed_q    <= 1'b0;
			hold_q       <= '0;
			long_done_q  <= 1'b0;
			vlong_done_q <= 1'b0;
		end else if (step) begin
			last_q       <= last_d;
			stable_q     <= stable_d;
			pressed_q    <= pressed_d;
			hold_q       <= hold_d;
			long_done_q  <= long_done_d;
			vlong_done_q <= vlong_done_d;
		end
	end

endmodule

/* rtl/bplb_led.sv */
module bplb_led (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic [bplb_pkg::MODE_W-1:0]     led_mode,
	input  logic [bplb_pkg::TICK_W-1:0]     tick_ms,
	output logic                            led_on
);

	logic [bplb_pkg::MODE_W-1:0]  mode_q;
	logic                         phase_q, phase_d;
	logic [bplb_pkg::PHASE_W-1:0] ptime_q, ptime_d;
	logic [bplb_pkg::PAT_W-1:0]   on_ms, off_ms, dur;

	always_comb begin
		phase_d = phase_q;
		ptime_d = ptime_q;
		on_ms   = bplb_pkg::pat_on(led_mode);
		off_ms  = bplb_pkg::pat_off(led_mode);
		dur     = '0;
		led_on  = 1'b0;

		// new mode restarts the pattern in its on phase
		if (led_mode != mode_q) begin
			phase_d = 1'b0;
			ptime_d = '0;
		end

		if (off_ms == '0) begin
			led_on = 1'b1;
		end else if (on_ms == '0) begin
			led_on = 1'b0;
		end else begin
			dur     = phase_d ? off_ms : on_ms;
			led_on  = !phase_d;
			ptime_d = ptime_d + bplb_pkg::PHASE_W'(tick_ms);
			if (ptime_d >= bplb_pkg::PHASE_W'(dur)) begin
				ptime_d = '0;
				phase_d = !phase_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= bplb_pkg::MODE_UNPAIRED;
			phase_q <= 1'b0;
			ptime_q <= '0;
		end else if (step) begin
			mode_q  <= led_mode;
			phase_q <= phase_d;
			ptime_q <= ptime_d;
		end
	end

endmodule
